[src/vector_distance_metric_defines.svh]
// Assertion macros for the vector distance block.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef VECTOR_DISTANCE_METRIC_DEFINES_SVH
`define VECTOR_DISTANCE_METRIC_DEFINES_SVH

// Same-cycle implication, off during reset.
`define VDM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define VDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/vdm_pkg.sv]
// Shared types, constants and single-precision arithmetic functions
// for the vector distance block. No dependencies.
package vdm_pkg;

  localparam logic [1:0] METRIC_L2      = 2'd0;
  localparam logic [1:0] METRIC_COS     = 2'd1;
  localparam logic [1:0] METRIC_DOT     = 2'd2;
  localparam logic [1:0] METRIC_NEG_DOT = 2'd3;

  localparam logic [31:0] FP_ONE         = 32'h3F80_0000;
  localparam logic [31:0] FP_NEG_ONE     = 32'hBF80_0000;
  localparam logic [31:0] FP_TINY        = 32'h0DA2_4260;  // 1e-30
  localparam logic [31:0] FP_QBIT        = 32'h0040_0000;
  localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] FP_CANON_NAN   = 32'h7FC0_0000;
  localparam logic [31:0] FP_SIGN        = 32'h8000_0000;
  localparam logic [30:0] FP_INF_MAG     = 31'h7F80_0000;

  typedef struct packed {
    logic [31:0] elem_a;
    logic [31:0] elem_b;
    logic        last;
  } vdm_item_t;

  typedef struct packed {
    logic busy;
    logic emit;
  } vdm_status_t;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  // Round to nearest even and pack; value is m * 2^k.
  function automatic logic [31:0] round_pack(input logic s, input int k,
                                             input logic [49:0] m);
    int          p;
    int          be;
    int          sh;
    logic [63:0] mw;
    logic [63:0] mant;
    logic [63:0] mask;
    logic        g;
    logic        st;
    logic        up;
    p  = 0;
    mw = {14'd0, m};
    if (m == 50'd0) return {s, 31'd0};
    for (int i = 0; i < 50; i++) begin
      if (m[i]) p = i;
    end
    be = p + k + 127;
    if (be < 1) be = 1;
    sh = be - 150 - k;
    if (sh <= 0) begin
      mant = mw << (-sh);
      g    = 1'b0;
      st   = 1'b0;
    end else if (sh > 63) begin
      mant = 64'd0;
      g    = 1'b0;
      st   = |mw;
    end else begin
      mant = mw >> sh;
      g    = mw[sh-1];
      mask = (64'd1 << (sh - 1)) - 64'd1;
      st   = |(mw & mask);
    end
    up   = g & (st | mant[0]);
    mant = mant + {63'd0, up};
    if (mant[24]) begin
      mant = mant >> 1;
      be   = be + 1;
    end
    if (be >= 255) return {s, 8'hFF, 23'd0};
    return {s, (mant[23] ? be[7:0] : 8'd0), mant[22:0]};
  endfunction

  // x + y, or x - y when sub is set; NaN of the first operand wins.
  function automatic logic [31:0] fp_addsub(input logic [31:0] x, input logic [31:0] y,
                                            input logic sub);
    logic [31:0] yv;
    logic        xi;
    logic        yi;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [23:0] mx;
    logic [23:0] my;
    logic [7:0]  el;
    logic [23:0] ml;
    logic [23:0] ms;
    logic        sl;
    logic        ss;
    int          d;
    logic [26:0] mle;
    logic [26:0] mse;
    logic [26:0] mss;
    logic [26:0] mask;
    logic [27:0] sum;
    logic        sg;
    if (is_nan(x)) return x | FP_QBIT;
    if (is_nan(y)) return y | FP_QBIT;
    yv = y ^ (sub ? FP_SIGN : 32'd0);
    xi = (x[30:0] == FP_INF_MAG);
    yi = (yv[30:0] == FP_INF_MAG);
    if (xi && yi && (x[31] != yv[31])) return FP_DEFAULT_NAN;
    if (xi) return x;
    if (yi) return yv;
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (yv[30:23] == 8'd0) ? 8'd1 : yv[30:23];
    mx = {x[30:23] != 8'd0, x[22:0]};
    my = {yv[30:23] != 8'd0, yv[22:0]};
    if (ex >= ey) begin
      el = ex; ml = mx; sl = x[31]; ms = my; ss = yv[31];
      d  = int'(ex) - int'(ey);
    end else begin
      el = ey; ml = my; sl = yv[31]; ms = mx; ss = x[31];
      d  = int'(ey) - int'(ex);
    end
    mle = {ml, 3'd0};
    mse = {ms, 3'd0};
    if (d >= 27) begin
      mss = {26'd0, ms != 24'd0};
    end else begin
      mask = (27'd1 << d) - 27'd1;
      mss  = (mse >> d) | {26'd0, |(mse & mask)};
    end
    if (sl == ss) begin
      sum = {1'b0, mle} + {1'b0, mss};
      sg  = sl;
    end else if (mle >= mss) begin
      sum = {1'b0, mle - mss};
      sg  = sl;
    end else begin
      sum = {1'b0, mss - mle};
      sg  = ss;
    end
    if (sum == 28'd0) return {x[31] & yv[31], 31'd0};
    return round_pack(sg, int'(el) - 153, {22'd0, sum});
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] x, input logic [31:0] y);
    logic        s;
    logic        xi;
    logic        yi;
    logic        xz;
    logic        yz;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [23:0] mx;
    logic [23:0] my;
    logic [47:0] pr;
    if (is_nan(x)) return x | FP_QBIT;
    if (is_nan(y)) return y | FP_QBIT;
    s  = x[31] ^ y[31];
    xi = (x[30:0] == FP_INF_MAG);
    yi = (y[30:0] == FP_INF_MAG);
    xz = (x[30:0] == 31'd0);
    yz = (y[30:0] == 31'd0);
    if ((xi && yz) || (yi && xz)) return FP_DEFAULT_NAN;
    if (xi || yi) return {s, FP_INF_MAG};
    if (xz || yz) return {s, 31'd0};
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx = {x[30:23] != 8'd0, x[22:0]};
    my = {y[30:23] != 8'd0, y[22:0]};
    pr = mx * my;
    return round_pack(s, int'(ex) + int'(ey) - 300, {2'd0, pr});
  endfunction

endpackage

[src/vdm_front.sv]
// Front end: takes element pairs off the input channel into a short queue.
// Depends on vdm_pkg for the queued word type.
module vdm_front #(
  parameter int Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       elem_a_i,
  input  logic [31:0]       elem_b_i,
  input  logic              last_element_i,
  output vdm_pkg::vdm_item_t head_o,
  output logic              head_valid_o,
  input  logic              pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  vdm_pkg::vdm_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic push;

  assign in_ready_o   = (cnt_q != CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i & in_ready_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{elem_a: elem_a_i, elem_b: elem_b_i, last: last_element_i};
    end
  end

endmodule

[src/vdm_sqrt.sv]
// Iterative single-precision square root, one root bit per cycle,
// correctly rounded. Depends on vdm_pkg for rounding and constants.
module vdm_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  localparam logic [1:0] SQ_IDLE = 2'd0;
  localparam logic [1:0] SQ_NORM = 2'd1;
  localparam logic [1:0] SQ_ITER = 2'd2;
  localparam logic [1:0] SQ_FIN  = 2'd3;

  logic [1:0]        state_q;
  logic signed [9:0] exp_q;
  logic [23:0]       mant_q;
  logic [51:0]       rad_q;
  logic [29:0]       rem_q;
  logic [25:0]       root_q;
  logic [4:0]        cnt_q;
  logic [31:0]       res_q;
  logic              done_q;

  logic [7:0]        be_eff;
  logic              odd;
  logic signed [9:0] exp_even;
  logic [29:0]       rem_n;
  logic [29:0]       trial;
  logic              special;
  logic              done_d;

  assign be_eff   = (rad_i[30:23] == 8'd0) ? 8'd1 : rad_i[30:23];
  assign odd      = exp_q[0];
  assign exp_even = exp_q - $signed({9'd0, odd});
  assign rem_n    = {rem_q[27:0], rad_q[51:50]};
  assign trial    = {2'd0, root_q, 2'b01};
  assign special  = vdm_pkg::is_nan(rad_i) || rad_i[31] || (rad_i[30:0] == 31'd0) ||
                    (rad_i[30:0] == vdm_pkg::FP_INF_MAG);
  assign done_d   = (state_q == SQ_FIN) || ((state_q == SQ_IDLE) && start_i && special);
  assign done_o   = done_q;
  assign root_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= done_d;
      unique case (state_q)
        SQ_IDLE: begin
          if (start_i) begin
            if (vdm_pkg::is_nan(rad_i) || rad_i[30:0] == 31'd0) begin
              res_q  <= rad_i;
            end else if (rad_i[31]) begin
              res_q  <= vdm_pkg::FP_CANON_NAN;
            end else if (rad_i[30:0] == vdm_pkg::FP_INF_MAG) begin
              res_q  <= rad_i;
            end else begin
              exp_q   <= $signed({2'd0, be_eff}) - 10'sd127;
              mant_q  <= {rad_i[30:23] != 8'd0, rad_i[22:0]};
              state_q <= SQ_NORM;
            end
          end
        end
        SQ_NORM: begin
          if (mant_q[23]) begin
            rad_q   <= odd ? {mant_q, 28'd0} : {1'b0, mant_q, 27'd0};
            exp_q   <= exp_even >>> 1;
            rem_q   <= '0;
            root_q  <= '0;
            cnt_q   <= 5'd25;
            state_q <= SQ_ITER;
          end else begin
            mant_q <= {mant_q[22:0], 1'b0};
            exp_q  <= exp_q - 10'sd1;
          end
        end
        SQ_ITER: begin
          if (rem_n >= trial) begin
            rem_q  <= rem_n - trial;
            root_q <= {root_q[24:0], 1'b1};
          end else begin
            rem_q  <= rem_n;
            root_q <= {root_q[24:0], 1'b0};
          end
          rad_q <= {rad_q[49:0], 2'd0};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) state_q <= SQ_FIN;
        end
        SQ_FIN: begin
          res_q   <= vdm_pkg::round_pack(1'b0, int'(exp_q) - 26,
                                         {23'd0, root_q, rem_q != 30'd0});
          state_q <= SQ_IDLE;
        end
        default: state_q <= SQ_IDLE;
      endcase
    end
  end

endmodule

[src/vdm_div.sv]
// Iterative single-precision divider, one quotient bit per cycle.
// The divisor must be a positive normal number. Depends on vdm_pkg.
module vdm_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_NORM = 2'd1;
  localparam logic [1:0] DV_ITER = 2'd2;
  localparam logic [1:0] DV_FIN  = 2'd3;

  logic [1:0]        state_q;
  logic              sign_q;
  logic signed [9:0] exp_q;
  logic signed [9:0] dexp_q;
  logic [23:0]       mant_q;
  logic [23:0]       den_q;
  logic [25:0]       rem_q;
  logic [24:0]       quo_q;
  logic [4:0]        cnt_q;
  logic [31:0]       res_q;
  logic              done_q;

  logic [7:0]  be_eff;
  logic        ge;
  logic [25:0] rem_sub;
  logic        done_d;

  assign be_eff  = (num_i[30:23] == 8'd0) ? 8'd1 : num_i[30:23];
  assign ge      = (rem_q >= {2'd0, den_q});
  assign rem_sub = ge ? (rem_q - {2'd0, den_q}) : rem_q;
  assign done_d  = (state_q == DV_FIN);
  assign done_o  = done_q;
  assign quot_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= done_d;
      unique case (state_q)
        DV_IDLE: begin
          if (start_i) begin
            sign_q  <= num_i[31] ^ den_i[31];
            exp_q   <= $signed({2'd0, be_eff}) - 10'sd127;
            mant_q  <= {num_i[30:23] != 8'd0, num_i[22:0]};
            dexp_q  <= $signed({2'd0, den_i[30:23]}) - 10'sd127;
            den_q   <= {1'b1, den_i[22:0]};
            state_q <= DV_NORM;
          end
        end
        DV_NORM: begin
          if (mant_q[23]) begin
            // keep the first quotient bit a one
            if (mant_q < den_q) begin
              rem_q <= {1'b0, mant_q, 1'b0};
              exp_q <= exp_q - dexp_q - 10'sd1;
            end else begin
              rem_q <= {2'd0, mant_q};
              exp_q <= exp_q - dexp_q;
            end
            quo_q   <= '0;
            cnt_q   <= 5'd24;
            state_q <= DV_ITER;
          end else begin
            mant_q <= {mant_q[22:0], 1'b0};
            exp_q  <= exp_q - 10'sd1;
          end
        end
        DV_ITER: begin
          rem_q <= {rem_sub[24:0], 1'b0};
          quo_q <= {quo_q[23:0], ge};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) state_q <= DV_FIN;
        end
        DV_FIN: begin
          res_q   <= vdm_pkg::round_pack(sign_q, int'(exp_q) - 25,
                                         {24'd0, quo_q, rem_q != 26'd0});
          state_q <= DV_IDLE;
        end
        default: state_q <= DV_IDLE;
      endcase
    end
  end

endmodule

[src/vdm_back.sv]
// Back end: sequences one shared adder and multiplier over the four running
// sums and finishes the chosen metric. Uses vdm_pkg, vdm_sqrt and vdm_div.
module vdm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           metric_i,
  input  vdm_pkg::vdm_item_t   head_i,
  input  logic                 head_valid_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          distance_o,
  output vdm_pkg::vdm_status_t status_o
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SUB      = 4'd1;
  localparam logic [3:0] ST_ACC_P    = 4'd2;
  localparam logic [3:0] ST_ACC_D    = 4'd3;
  localparam logic [3:0] ST_ACC_A    = 4'd4;
  localparam logic [3:0] ST_ACC_B    = 4'd5;
  localparam logic [3:0] ST_NORM_MUL = 4'd6;
  localparam logic [3:0] ST_SQRT     = 4'd7;
  localparam logic [3:0] ST_DIV      = 4'd8;
  localparam logic [3:0] ST_FSUB     = 4'd9;
  localparam logic [3:0] ST_EMIT     = 4'd10;

  logic [3:0]  state_q;
  logic [31:0] a_q, b_q;
  logic        last_q;
  logic [31:0] diff_q, prod_q;
  logic [31:0] sd_q, sp_q, s1_q, s2_q;
  logic [31:0] sim_q, res_q;
  logic        out_valid_q;
  logic [31:0] dist_q;

  logic [31:0] add_x, add_y, add_res;
  logic        add_sub;
  logic [31:0] mul_x, mul_y, mul_res;
  logic        emit;

  logic        sqrt_done, div_done, div_start;
  logic [31:0] sqrt_root, div_quot;
  logic        sim_special;
  logic [31:0] sim_val;
  logic [31:0] sim_clamped;

  vdm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_NORM_MUL),
    .rad_i   (mul_res),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  vdm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sp_q),
    .den_i   (sqrt_root),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    mul_x   = '0;
    mul_y   = '0;
    unique case (state_q)
      ST_SUB:      begin add_x = a_q;  add_y = b_q;    add_sub = 1'b1;
                         mul_x = a_q;  mul_y = b_q;    end
      ST_ACC_P:    begin add_x = sp_q; add_y = prod_q;
                         mul_x = diff_q; mul_y = diff_q; end
      ST_ACC_D:    begin add_x = sd_q; add_y = prod_q;
                         mul_x = a_q;  mul_y = a_q;    end
      ST_ACC_A:    begin add_x = s1_q; add_y = prod_q;
                         mul_x = b_q;  mul_y = b_q;    end
      ST_ACC_B:    begin add_x = s2_q; add_y = prod_q; end
      ST_NORM_MUL: begin mul_x = s1_q; mul_y = s2_q;   end
      ST_FSUB:     begin add_x = vdm_pkg::FP_ONE; add_y = sim_q; add_sub = 1'b1; end
      default:     begin end
    endcase
  end

  assign add_res = vdm_pkg::fp_addsub(add_x, add_y, add_sub);
  assign mul_res = vdm_pkg::fp_mul(mul_x, mul_y);

  // Similarity for the cases the divider does not cover.
  always_comb begin
    sim_special = 1'b1;
    sim_val     = 32'd0;
    priority if (vdm_pkg::is_nan(sqrt_root)) begin
      sim_val = vdm_pkg::FP_NEG_ONE;
    end else if (sqrt_root[31] || sqrt_root[30:0] < vdm_pkg::FP_TINY[30:0]) begin
      sim_val = 32'd0;
    end else if (vdm_pkg::is_nan(sp_q)) begin
      sim_val = vdm_pkg::FP_NEG_ONE;
    end else if (sqrt_root[30:0] == vdm_pkg::FP_INF_MAG) begin
      sim_val = (sp_q[30:0] == vdm_pkg::FP_INF_MAG) ? vdm_pkg::FP_NEG_ONE : 32'd0;
    end else if (sp_q[30:0] == vdm_pkg::FP_INF_MAG) begin
      sim_val = {sp_q[31], vdm_pkg::FP_ONE[30:0]};
    end else if (sp_q[30:0] == 31'd0) begin
      sim_val = sp_q;
    end else begin
      sim_special = 1'b0;
    end
  end

  assign div_start   = (state_q == ST_SQRT) && sqrt_done && !sim_special;
  assign sim_clamped = (div_quot[30:0] > vdm_pkg::FP_ONE[30:0])
                     ? {div_quot[31], vdm_pkg::FP_ONE[30:0]} : div_quot;
  assign emit        = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign pop_o       = (state_q == ST_IDLE) && head_valid_i;

  assign out_valid_o   = out_valid_q;
  assign distance_o    = dist_q;
  assign status_o.busy = (state_q != ST_IDLE);
  assign status_o.emit = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sd_q        <= '0;
      sp_q        <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE:  if (head_valid_i) state_q <= ST_SUB;
        ST_SUB:   state_q <= ST_ACC_P;
        ST_ACC_P: begin sp_q <= add_res; state_q <= ST_ACC_D; end
        ST_ACC_D: begin sd_q <= add_res; state_q <= ST_ACC_A; end
        ST_ACC_A: begin s1_q <= add_res; state_q <= ST_ACC_B; end
        ST_ACC_B: begin
          s2_q <= add_res;
          if (!last_q) begin
            state_q <= ST_IDLE;
          end else begin
            unique case (metric_i)
              vdm_pkg::METRIC_L2:      begin res_q <= sd_q; state_q <= ST_EMIT; end
              vdm_pkg::METRIC_COS:     state_q <= ST_NORM_MUL;
              vdm_pkg::METRIC_DOT:     begin res_q <= sp_q; state_q <= ST_EMIT; end
              vdm_pkg::METRIC_NEG_DOT: begin
                res_q   <= sp_q ^ vdm_pkg::FP_SIGN;
                state_q <= ST_EMIT;
              end
              default: state_q <= ST_EMIT;
            endcase
          end
        end
        ST_NORM_MUL: state_q <= ST_SQRT;
        ST_SQRT: begin
          if (sqrt_done) begin
            if (sim_special) begin
              sim_q   <= sim_val;
              state_q <= ST_FSUB;
            end else begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            sim_q   <= sim_clamped;
            state_q <= ST_FSUB;
          end
        end
        ST_FSUB: begin res_q <= add_res; state_q <= ST_EMIT; end
        ST_EMIT: begin
          if (emit) begin
            // drop the sums for the next vector
            sd_q    <= '0;
            sp_q    <= '0;
            s1_q    <= '0;
            s2_q    <= '0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_q    <= head_i.elem_a;
      b_q    <= head_i.elem_b;
      last_q <= head_i.last;
    end
    if (state_q == ST_SUB) begin
      diff_q <= add_res;
    end
    if (state_q == ST_SUB || state_q == ST_ACC_P || state_q == ST_ACC_D ||
        state_q == ST_ACC_A) begin
      prod_q <= mul_res;
    end
    if (emit) begin
      dist_q <= res_q;
    end
  end

endmodule

[src/vector_distance_metric.sv]
// Vector distance unit: squared L2, cosine distance, dot or negated dot.
// Input channel (in_valid_i/in_ready_o) moves one word: one float32 element
// of each vector plus last_element_i on the final pair. Output channel
// (out_valid_o/out_ready_i) moves one float32 distance per vector, after the
// word marked last. The metric register is written over cfg_valid_i /
// cfg_ready_o with metric_i, always ready, and is read when the last word
// is processed.
// In the back end each pair steps the single shared adder and multiplier
// through the difference, four products and four sums. The front queue
// takes words while the back end works or while a result waits. After the
// last pair, L2 and dot metrics go straight to the result; cosine runs
// through the bit-serial square root (26 steps) and divider (25 steps),
// with normalizing shifts for subnormal operands, or skips the divide
// for a zero, tiny, infinite or NaN sum.
// Reset clears the sums to +0, the metric to squared L2 and the queue.
// A stalled receiver holds the result in the output register; the back end
// stops at the next result and the queue then fills and drops in_ready_o.
`include "vector_distance_metric_defines.svh"
module vector_distance_metric #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] elem_a_i,
  input  logic [31:0] elem_b_i,
  input  logic        last_element_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] distance_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  metric_i
);

  logic [1:0]           metric_q;
  vdm_pkg::vdm_item_t   head;
  logic                 head_valid;
  logic                 pop;
  vdm_pkg::vdm_status_t status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= vdm_pkg::METRIC_L2;
    end else if (cfg_valid_i) begin
      metric_q <= metric_i;
    end
  end

  vdm_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .elem_a_i       (elem_a_i),
    .elem_b_i       (elem_b_i),
    .last_element_i (last_element_i),
    .head_o         (head),
    .head_valid_o   (head_valid),
    .pop_i          (pop)
  );

  vdm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .metric_i     (metric_q),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .distance_o   (distance_o),
    .status_o     (status)
  );

  `VDM_ASSERT_IMPL(a_pop_needs_word, pop, head_valid && !status.busy, "pop without word")
  `VDM_ASSERT_IMPL(a_no_overwrite, status.emit, !out_valid_o || out_ready_i, "result lost")
  `VDM_ASSERT_NEXT(a_emit_shows, status.emit, out_valid_o, "result not shown")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for vector_distance_metric: directed table then random vectors.
// Bit-exact float32 predictor of the running sums and the four metrics.
// Depends on vdm_pkg for metric codes and float constants.
`timescale 1ns / 100ps
module tb_top;

  typedef struct {
    logic        is_cfg;
    logic [1:0]  metric;
    logic [31:0] a;
    logic [31:0] b;
    logic        last;
    logic        typed;
    logic [31:0] exp_dist;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [31:0] elem_a = '0;
  logic [31:0] elem_b = '0;
  logic        last_element = 1'b0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [31:0] distance_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  metric_wr = '0;

  logic [31:0] sum_sq_diff_q, sum_products_q, sum_sq_first_q, sum_sq_second_q;
  logic [1:0]  metric_q;
  logic [31:0] distance_q[$];
  logic [32:0] typed_q[$];
  row_t        rows[$];
  int          errors = 0;
  int          stall_left = 0;
  logic [31:0] cyc = '0;

  vector_distance_metric uut (
    .clk_i(clk), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready_o),
    .elem_a_i(elem_a), .elem_b_i(elem_b), .last_element_i(last_element),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready), .distance_o(distance_o),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready_o), .metric_i(metric_wr)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------- float32 arithmetic, round to nearest even ----------------
  function automatic logic nan32(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 0);
  endfunction

  function automatic logic inf32(input logic [31:0] x);
    return x[30:0] == 31'h7F80_0000;
  endfunction

  // value is m * 2^k
  function automatic logic [31:0] round_to_fp32(input logic s, input int k,
                                                input logic [63:0] m);
    int          msb;
    int          be;
    int          sh;
    logic [63:0] q;
    logic        gbit;
    logic        sbit;
    if (m == 0) return {s, 31'd0};
    msb = 0;
    for (int i = 0; i < 64; i++) if (m[i]) msb = i;
    be = msb + k + 127;
    if (be < 1) be = 1;
    sh = be - 150 - k;
    if (sh <= 0) begin
      q = m << (-sh); gbit = 1'b0; sbit = 1'b0;
    end else if (sh > 64) begin
      q = 0; gbit = 1'b0; sbit = 1'b1;
    end else begin
      q    = m >> sh;
      gbit = m[sh-1];
      sbit = (sh > 1) ? |(m & ((64'd1 << (sh - 1)) - 64'd1)) : 1'b0;
    end
    if (gbit && (sbit || q[0])) q = q + 1;
    if (q[24]) begin
      q  = q >> 1;
      be = be + 1;
    end
    if (be >= 255) return {s, 8'hFF, 23'd0};
    return {s, (q[23] ? be[7:0] : 8'd0), q[22:0]};
  endfunction

  function automatic logic [31:0] fp32_add(input logic [31:0] x, input logic [31:0] y);
    int          ex, ey, el, d;
    logic [39:0] ml, ms, mss;
    logic [40:0] sum;
    logic        sl, ss, sg;
    if (nan32(x)) return x | vdm_pkg::FP_QBIT;
    if (nan32(y)) return y | vdm_pkg::FP_QBIT;
    if (inf32(x) && inf32(y) && x[31] != y[31]) return vdm_pkg::FP_DEFAULT_NAN;
    if (inf32(x)) return x;
    if (inf32(y)) return y;
    ex = (x[30:23] == 0) ? 1 : int'(x[30:23]);
    ey = (y[30:23] == 0) ? 1 : int'(y[30:23]);
    if (ex >= ey) begin
      el = ex; d = ex - ey; sl = x[31]; ss = y[31];
      ml = {x[30:23] != 0, x[22:0], 16'd0};
      ms = {y[30:23] != 0, y[22:0], 16'd0};
    end else begin
      el = ey; d = ey - ex; sl = y[31]; ss = x[31];
      ml = {y[30:23] != 0, y[22:0], 16'd0};
      ms = {x[30:23] != 0, x[22:0], 16'd0};
    end
    if (d >= 40) mss = {39'd0, ms != 0};
    else mss = (ms >> d) | {39'd0, |(ms & ((40'd1 << d) - 40'd1))};
    if (sl == ss) begin
      sum = {1'b0, ml} + {1'b0, mss}; sg = sl;
    end else if (ml >= mss) begin
      sum = {1'b0, ml - mss}; sg = sl;
    end else begin
      sum = {1'b0, mss - ml}; sg = ss;
    end
    if (sum == 0) return {x[31] & y[31], 31'd0};
    return round_to_fp32(sg, el - 166, {23'd0, sum});
  endfunction

  function automatic logic [31:0] fp32_mul(input logic [31:0] x, input logic [31:0] y);
    logic        s;
    int          ex, ey;
    logic [47:0] pr;
    if (nan32(x)) return x | vdm_pkg::FP_QBIT;
    if (nan32(y)) return y | vdm_pkg::FP_QBIT;
    s = x[31] ^ y[31];
    if ((inf32(x) && y[30:0] == 0) || (inf32(y) && x[30:0] == 0))
      return vdm_pkg::FP_DEFAULT_NAN;
    if (inf32(x) || inf32(y)) return {s, vdm_pkg::FP_INF_MAG};
    if (x[30:0] == 0 || y[30:0] == 0) return {s, 31'd0};
    ex = (x[30:23] == 0) ? 1 : int'(x[30:23]);
    ey = (y[30:23] == 0) ? 1 : int'(y[30:23]);
    pr = {x[30:23] != 0, x[22:0]} * {y[30:23] != 0, y[22:0]};
    return round_to_fp32(s, ex + ey - 300, {16'd0, pr});
  endfunction

  function automatic logic [31:0] fp32_div(input logic [31:0] x, input logic [31:0] y);
    logic        s;
    int          ex, ey;
    logic [63:0] mx, my, q, r;
    if (nan32(x)) return x | vdm_pkg::FP_QBIT;
    if (nan32(y)) return y | vdm_pkg::FP_QBIT;
    s = x[31] ^ y[31];
    if (inf32(x) && inf32(y)) return vdm_pkg::FP_DEFAULT_NAN;
    if (inf32(x)) return {s, vdm_pkg::FP_INF_MAG};
    if (inf32(y)) return {s, 31'd0};
    if (y[30:0] == 0)
      return (x[30:0] == 0) ? vdm_pkg::FP_DEFAULT_NAN : {s, vdm_pkg::FP_INF_MAG};
    if (x[30:0] == 0) return {s, 31'd0};
    ex = (x[30:23] == 0) ? 1 : int'(x[30:23]);
    ey = (y[30:23] == 0) ? 1 : int'(y[30:23]);
    mx = {40'd0, x[30:23] != 0, x[22:0]};
    my = {40'd0, y[30:23] != 0, y[22:0]};
    while (!mx[23]) begin mx = mx << 1; ex--; end
    while (!my[23]) begin my = my << 1; ey--; end
    q = (mx << 40) / my;
    r = (mx << 40) % my;
    return round_to_fp32(s, ex - ey - 41, (q << 1) | {63'd0, r != 0});
  endfunction

  function automatic logic [31:0] fp32_sqrt(input logic [31:0] x);
    int          e;
    logic [63:0] m, big, root, t;
    if (nan32(x)) return x | vdm_pkg::FP_QBIT;
    if (x[30:0] == 0) return x;
    if (x[31]) return vdm_pkg::FP_CANON_NAN;
    if (inf32(x)) return x;
    e = ((x[30:23] == 0) ? 1 : int'(x[30:23])) - 150;
    m = {40'd0, x[30:23] != 0, x[22:0]};
    while (!m[23]) begin m = m << 1; e--; end
    if (e % 2 != 0) begin m = m << 1; e--; end
    big  = m << 38;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      t = root | (64'd1 << i);
      if (t * t <= big) root = t;
    end
    return round_to_fp32(1'b0, (e - 38) / 2 - 1, (root << 1) | {63'd0, root * root != big});
  endfunction

  // ordered compare, neither operand NaN
  function automatic logic fp32_less(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] kx, ky;
    kx = x[31] ? ~x : (x | vdm_pkg::FP_SIGN);
    ky = y[31] ? ~y : (y | vdm_pkg::FP_SIGN);
    return kx < ky;
  endfunction

  function automatic logic [31:0] cosine_distance();
    logic [31:0] den, sim;
    den = fp32_sqrt(fp32_mul(sum_sq_first_q, sum_sq_second_q));
    if (!nan32(den) && fp32_less(den, vdm_pkg::FP_TINY)) return vdm_pkg::FP_ONE;
    sim = fp32_div(sum_products_q, den);
    if (nan32(sim) || fp32_less(sim, vdm_pkg::FP_NEG_ONE)) sim = vdm_pkg::FP_NEG_ONE;
    if (fp32_less(vdm_pkg::FP_ONE, sim)) sim = vdm_pkg::FP_ONE;
    return fp32_add(vdm_pkg::FP_ONE, sim ^ vdm_pkg::FP_SIGN);
  endfunction

  // Fold one pair into the sums; on the last pair return the distance.
  function automatic logic accumulate_pair(input logic [31:0] a, input logic [31:0] b,
                                           input logic last, output logic [31:0] res);
    logic [31:0] diff;
    if (nan32(b) && !nan32(a)) diff = b | vdm_pkg::FP_QBIT;
    else diff = fp32_add(a, b ^ vdm_pkg::FP_SIGN);
    sum_sq_diff_q   = fp32_add(sum_sq_diff_q, fp32_mul(diff, diff));
    sum_products_q  = fp32_add(sum_products_q, fp32_mul(a, b));
    sum_sq_first_q  = fp32_add(sum_sq_first_q, fp32_mul(a, a));
    sum_sq_second_q = fp32_add(sum_sq_second_q, fp32_mul(b, b));
    res = '0;
    if (!last) return 1'b0;
    case (metric_q)
      vdm_pkg::METRIC_L2:  res = sum_sq_diff_q;
      vdm_pkg::METRIC_COS: res = cosine_distance();
      vdm_pkg::METRIC_DOT: res = sum_products_q;
      default:             res = sum_products_q ^ vdm_pkg::FP_SIGN;
    endcase
    sum_sq_diff_q   = '0;
    sum_products_q  = '0;
    sum_sq_first_q  = '0;
    sum_sq_second_q = '0;
    return 1'b1;
  endfunction

  // ---------------- monitors ----------------
  always @(posedge clk) cyc <= cyc + 1;

  always @(posedge clk or negedge rst_ni) begin
    logic [31:0] got_dist;
    logic [32:0] tag;
    if (!rst_ni) begin
      metric_q        = vdm_pkg::METRIC_L2;
      sum_sq_diff_q   = '0;
      sum_products_q  = '0;
      sum_sq_first_q  = '0;
      sum_sq_second_q = '0;
    end else begin
      if (cfg_valid && cfg_ready_o) metric_q = metric_wr;
      if (in_valid && in_ready_o) begin
        tag = typed_q.pop_front();
        if (accumulate_pair(elem_a, elem_b, last_element, got_dist))
          distance_q.push_back(tag[32] ? tag[31:0] : got_dist);
      end
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (distance_q.size() == 0) begin
        $error("distance: unexpected word %h", distance_o);
        errors++;
      end else begin
        want = distance_q.pop_front();
        if (distance_o !== want) begin
          $error("distance: expected %h, actual %h", want, distance_o);
          errors++;
        end
      end
    end
    // receiver: always ready in calm stretches, otherwise random stalls
    if (cyc[9]) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < 3) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(10, 50);
    end else begin
      out_ready <= ($urandom_range(0, 99) < 75);
    end
  end

  // ---------------- stimulus ----------------
  function automatic int pick_gap();
    int r;
    if (cyc[9]) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_elem();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 150)),
                        23'($urandom)};
    if (r < 82) return $urandom;
    if (r < 92) return {$urandom_range(0, 1) == 1, 8'($urandom_range(124, 130)),
                        23'($urandom) & 23'h7F_0000};
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return 32'h7FC0_0000;
      5: return 32'h0000_0001;
      6: return 32'h7F7F_FFFF;
      default: return 32'hFF7F_FFFF;
    endcase
  endfunction

  task automatic send_pair(input logic [31:0] a, input logic [31:0] b, input logic last,
                           input logic typed, input logic [31:0] exp_dist);
    int gap;
    typed_q.push_back({typed, exp_dist});
    in_valid     <= 1'b1;
    elem_a       <= a;
    elem_b       <= b;
    last_element <= last;
    do @(posedge clk); while (!in_ready_o);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every distance is back and the back end has drained.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (distance_q.size() != 0 || typed_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_metric(input logic [1:0] m);
    wait_idle();
    cfg_valid <= 1'b1;
    metric_wr <= m;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_cfg(input logic [1:0] m);
    rows.push_back('{1'b1, m, '0, '0, 1'b0, 1'b0, '0});
  endfunction

  function automatic void add_pair(input logic [31:0] a, input logic [31:0] b,
                                   input logic last, input logic typed,
                                   input logic [31:0] exp_dist);
    rows.push_back('{1'b0, vdm_pkg::METRIC_L2, a, b, last, typed, exp_dist});
  endfunction

  initial begin
    int sent;
    int vecs;
    int len;
    logic [1:0] m;

    // metric stays at its reset value (squared L2) for the first rows
    add_pair(32'h4040_0000, vdm_pkg::FP_ONE, 1'b1, 1'b1, 32'h4080_0000);
    add_pair(32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b1, 1'b1, 32'h7F80_0000);
    add_pair(32'hFFA0_0000, vdm_pkg::FP_ONE, 1'b1, 1'b1, 32'hFFE0_0000);
    add_pair(32'h0000_0001, 32'h8000_0001, 1'b0, 1'b0, '0);
    add_pair(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, '0);
    add_cfg(vdm_pkg::METRIC_DOT);
    add_pair(32'h4000_0000, 32'h4040_0000, 1'b1, 1'b1, 32'h40C0_0000);
    add_pair(32'h7F80_0000, 32'h0000_0000, 1'b1, 1'b1, vdm_pkg::FP_DEFAULT_NAN);
    add_cfg(vdm_pkg::METRIC_NEG_DOT);
    add_pair(32'h4000_0000, 32'h4040_0000, 1'b1, 1'b1, 32'hC0C0_0000);
    add_pair(32'hFFFF_FFFF, vdm_pkg::FP_ONE, 1'b1, 1'b0, '0);
    add_cfg(vdm_pkg::METRIC_COS);
    add_pair(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, vdm_pkg::FP_ONE);
    add_pair(vdm_pkg::FP_ONE, vdm_pkg::FP_ONE, 1'b1, 1'b1, 32'h0000_0000);
    add_pair(vdm_pkg::FP_ONE, vdm_pkg::FP_NEG_ONE, 1'b1, 1'b1, 32'h4000_0000);
    add_pair(32'h7FC0_0000, vdm_pkg::FP_ONE, 1'b1, 1'b1, 32'h4000_0000);
    add_pair(32'h0000_0001, 32'h0000_0001, 1'b1, 1'b1, vdm_pkg::FP_ONE);
    add_pair(32'h3F00_0000, 32'h4000_0000, 1'b0, 1'b0, '0);
    add_pair(32'hC0A0_0000, 32'h3E80_0000, 1'b0, 1'b0, '0);
    add_pair(32'h4110_0000, 32'hBF40_0000, 1'b1, 1'b0, '0);
    add_cfg(vdm_pkg::METRIC_L2);
    add_pair(32'h0000_0000, 32'h8000_0000, 1'b1, 1'b1, 32'h0000_0000);

    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_metric(rows[i].metric);
      else send_pair(rows[i].a, rows[i].b, rows[i].last, rows[i].typed,
                     rows[i].exp_dist);
    end

    sent = 0;
    vecs = 0;
    while (sent < 800) begin
      if (vecs % 25 == 0) begin
        case ((vecs / 25) % 6)
          0: m = vdm_pkg::METRIC_NEG_DOT;
          1: m = vdm_pkg::METRIC_L2;
          default: m = 2'($urandom);
        endcase
        write_metric(m);
      end
      // pause until the pipeline is empty, once mid-run
      if (vecs == 60) wait_idle();
      len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 4) : $urandom_range(5, 16);
      for (int k = 0; k < len; k++)
        send_pair(rand_elem(), rand_elem(), k == len - 1, 1'b0, '0);
      sent += len;
      vecs++;
    end

    wait_idle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
